/* design/cte_pkg.sv */
// cte_pkg: field widths, calendar constants and the month-day table for the
// calendar to epoch millisecond converter; no dependencies
`default_nettype none

package cte_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int MILLI_W  = 10;
    localparam int EPOCH_W  = 48;

    localparam int BASE_YEAR = 1970;

    localparam int MS_PER_SEC     = 1000;
    localparam int MINUTE_SECONDS = 60;
    localparam int HOUR_SECONDS   = 3600;
    localparam int DAY_SECONDS    = 86400;
    localparam int DAYS_PER_YR    = 365;
    localparam int CENTURY        = 100;
    localparam int MONTH_MAX      = 12;

    // floor(n / 100) = (n * DIV100_MUL) >> DIV100_SHIFT for any 14-bit n
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int PROD_W       = 27;
    localparam int Q_W          = PROD_W - DIV100_SHIFT;

    localparam int LEAPS_BASE = (BASE_YEAR - 1) / 4 - (BASE_YEAR - 1) / 100
                              + (BASE_YEAR - 1) / 400;

    localparam int MIDX_W  = 4;
    localparam int DBM_W   = 9;
    localparam int LEAPC_W = 13;
    localparam int DAYS_W  = 23;
    localparam int TOD_W   = 17;
    localparam int SECS_W  = 39;

    typedef struct packed {
        logic [DAYS_W-1:0]  days;
        logic [TOD_W-1:0]   tod_s;
        logic [MILLI_W-1:0] milli;
    } cte_day_t;

    // days before the start of month index midx (0 is january), twelve is the year length
    function automatic logic [DBM_W-1:0] days_before_month(input logic leap,
                                                          input logic [MIDX_W-1:0] midx);
        logic [DBM_W-1:0] common;
        begin
            unique case (midx)
                4'd0:    common = 9'd0;
                4'd1:    common = 9'd31;
                4'd2:    common = 9'd59;
                4'd3:    common = 9'd90;
                4'd4:    common = 9'd120;
                4'd5:    common = 9'd151;
                4'd6:    common = 9'd181;
                4'd7:    common = 9'd212;
                4'd8:    common = 9'd243;
                4'd9:    common = 9'd273;
                4'd10:   common = 9'd304;
                4'd11:   common = 9'd334;
                default: common = 9'd365;
            endcase
            days_before_month = common + DBM_W'(leap && (midx >= 4'd2));
        end
    endfunction

endpackage

`default_nettype wire

/* design/cte_days.sv */
// cte_days: first three pipeline stages, calendar fields to whole days,
// second of day and millisecond; depends on cte_pkg
`default_nettype none

module cte_days (
    input  wire logic                           aclk,
    input  wire logic                           en,
    input  wire logic [cte_pkg::YEAR_W-1:0]     year_in,
    input  wire logic [cte_pkg::MONTH_W-1:0]    month_in,
    input  wire logic [cte_pkg::DAY_W-1:0]      day_in,
    input  wire logic [cte_pkg::HOUR_W-1:0]     hour_in,
    input  wire logic [cte_pkg::MINUTE_W-1:0]   minute_in,
    input  wire logic [cte_pkg::SECOND_W-1:0]   second_in,
    input  wire logic [cte_pkg::MILLI_W-1:0]    milli_in,
    output cte_pkg::cte_day_t                   day_out
);
    import cte_pkg::*;

    // stage 1
    logic               gt1_reg,    gt1_next;
    logic [YEAR_W-1:0]  year1_reg,  year1_next;
    logic [YEAR_W-1:0]  span1_reg,  span1_next;
    logic [YEAR_W-1:0]  ym1_1_reg,  ym1_1_next;
    logic [PROD_W-1:0]  py1_reg,    py1_next;
    logic [PROD_W-1:0]  pym1_reg,   pym1_next;
    logic [MIDX_W-1:0]  midx1_reg,  midx1_next;
    logic [DAY_W-1:0]   doff1_reg,  doff1_next;
    logic [TOD_W-1:0]   tod1_reg,   tod1_next;
    logic [MILLI_W-1:0] milli1_reg;

    // stage 2
    logic               gt2_reg;
    logic               leap2_reg,  leap2_next;
    logic [DAYS_W-1:0]  span365_reg, span365_next;
    logic [LEAPC_W-1:0] leapc2_reg, leapc2_next;
    logic [MIDX_W-1:0]  midx2_reg;
    logic [DAY_W-1:0]   doff2_reg;
    logic [TOD_W-1:0]   tod2_reg;
    logic [MILLI_W-1:0] milli2_reg;

    // stage 3
    cte_day_t           day3_reg,   day3_next;

    logic [Q_W-1:0]     q_y;
    logic [Q_W-1:0]     q_ym1;
    logic [YEAR_W-1:0]  rem_y;

    always_comb begin
        gt1_next   = year_in > YEAR_W'(BASE_YEAR);
        year1_next = year_in;
        span1_next = year_in - YEAR_W'(BASE_YEAR);
        ym1_1_next = year_in - YEAR_W'(1);
        py1_next   = PROD_W'(year_in) * PROD_W'(DIV100_MUL);
        pym1_next  = PROD_W'(ym1_1_next) * PROD_W'(DIV100_MUL);
        if (month_in == '0) begin
            midx1_next = '0;
        end else if (month_in > MONTH_W'(MONTH_MAX)) begin
            midx1_next = MIDX_W'(MONTH_MAX);
        end else begin
            midx1_next = month_in - MONTH_W'(1);
        end
        doff1_next = (day_in == '0) ? '0 : day_in - DAY_W'(1);
        tod1_next  = TOD_W'(hour_in) * TOD_W'(HOUR_SECONDS)
                   + TOD_W'(minute_in) * TOD_W'(MINUTE_SECONDS)
                   + TOD_W'(second_in);
    end

    always_comb begin
        q_y          = py1_reg[PROD_W-1 -: Q_W];
        q_ym1        = pym1_reg[PROD_W-1 -: Q_W];
        rem_y        = year1_reg - YEAR_W'(q_y) * YEAR_W'(CENTURY);
        leap2_next   = (rem_y == '0) ? (q_y[1:0] == 2'b00) : (year1_reg[1:0] == 2'b00);
        leapc2_next  = LEAPC_W'(ym1_1_reg[YEAR_W-1:2]) - LEAPC_W'(q_ym1)
                     + LEAPC_W'(q_ym1[Q_W-1:2]) - LEAPC_W'(LEAPS_BASE);
        span365_next = DAYS_W'(span1_reg) * DAYS_W'(DAYS_PER_YR);
    end

    always_comb begin
        day3_next.days  = (gt2_reg ? span365_reg + DAYS_W'(leapc2_reg) : '0)
                        + DAYS_W'(days_before_month(leap2_reg, midx2_reg))
                        + DAYS_W'(doff2_reg);
        day3_next.tod_s = tod2_reg;
        day3_next.milli = milli2_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            gt1_reg     <= gt1_next;
            year1_reg   <= year1_next;
            span1_reg   <= span1_next;
            ym1_1_reg   <= ym1_1_next;
            py1_reg     <= py1_next;
            pym1_reg    <= pym1_next;
            midx1_reg   <= midx1_next;
            doff1_reg   <= doff1_next;
            tod1_reg    <= tod1_next;
            milli1_reg  <= milli_in;

            gt2_reg     <= gt1_reg;
            leap2_reg   <= leap2_next;
            span365_reg <= span365_next;
            leapc2_reg  <= leapc2_next;
            midx2_reg   <= midx1_reg;
            doff2_reg   <= doff1_reg;
            tod2_reg    <= tod1_reg;
            milli2_reg  <= milli1_reg;

            day3_reg    <= day3_next;
        end
    end

    assign day_out = day3_reg;

endmodule

`default_nettype wire

/* design/cte_ms.sv */
// cte_ms: last two pipeline stages, days and second of day to seconds,
// then to milliseconds; depends on cte_pkg
`default_nettype none

module cte_ms (
    input  wire logic                       aclk,
    input  wire logic                       en,
    input  wire cte_pkg::cte_day_t          day_in,
    output logic [cte_pkg::EPOCH_W-1:0]     epoch_ms
);
    import cte_pkg::*;

    logic [SECS_W-1:0]  secs_reg,  secs_next;
    logic [MILLI_W-1:0] milli_reg;
    logic [EPOCH_W-1:0] ms_reg,    ms_next;

    always_comb begin
        secs_next = SECS_W'(day_in.days) * SECS_W'(DAY_SECONDS) + SECS_W'(day_in.tod_s);
        ms_next   = EPOCH_W'(secs_reg) * EPOCH_W'(MS_PER_SEC) + EPOCH_W'(milli_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            secs_reg  <= secs_next;
            milli_reg <= day_in.milli;
            ms_reg    <= ms_next;
        end
    end

    assign epoch_ms = ms_reg;

endmodule

`default_nettype wire

/* design/calendar_to_epoch_milliseconds_unit.sv */
// calendar_to_epoch_milliseconds_unit: top level, handshake and valid pipeline
// depends on cte_pkg, cte_days and cte_ms
//
// Converts a UTC Gregorian calendar time into milliseconds since midnight
// UTC at the start of the base year. Fields are taken as they come: a day
// past the end of its month simply adds days, month zero counts as january,
// month above twelve counts a whole year.
// Input channel s_*: one transfer carries one calendar time.
// Output channel m_*: one transfer carries one result, in input order.
// Throughput is one item per cycle while the output is not stalled, set by
// the five-stage pipeline (year split and reciprocal multiplies, leap count,
// day sum, seconds, milliseconds).
// The last stage is the output register. When m_ready is low with a
// result waiting, the whole pipeline holds and s_ready drops; bubbles
// inside the pipeline do not stop new input transfers.
// Reset (aresetn low, synchronous) clears every valid bit; data registers
// are not reset.
`default_nettype none

module calendar_to_epoch_milliseconds_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [cte_pkg::YEAR_W-1:0]     s_year_in,
    input  wire logic [cte_pkg::MONTH_W-1:0]    s_month_in,
    input  wire logic [cte_pkg::DAY_W-1:0]      s_day_in,
    input  wire logic [cte_pkg::HOUR_W-1:0]     s_hour_in,
    input  wire logic [cte_pkg::MINUTE_W-1:0]   s_minute_in,
    input  wire logic [cte_pkg::SECOND_W-1:0]   s_second_in,
    input  wire logic [cte_pkg::MILLI_W-1:0]    s_milli_in,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [cte_pkg::EPOCH_W-1:0]         m_epoch_ms
);
    import cte_pkg::*;

    localparam int LAT = 5;

    logic [LAT-1:0] vld_reg, vld_next;
    logic           en;
    cte_day_t       day_mid;

    assign en      = !vld_reg[LAT-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];

    always_comb begin
        vld_next = {vld_reg[LAT-2:0], s_valid && en};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    cte_days u_days (
        .aclk      (aclk),
        .en        (en),
        .year_in   (s_year_in),
        .month_in  (s_month_in),
        .day_in    (s_day_in),
        .hour_in   (s_hour_in),
        .minute_in (s_minute_in),
        .second_in (s_second_in),
        .milli_in  (s_milli_in),
        .day_out   (day_mid)
    );

    cte_ms u_ms (
        .aclk     (aclk),
        .en       (en),
        .day_in   (day_mid),
        .epoch_ms (m_epoch_ms)
    );

`ifndef SYNTHESIS
    a_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $past(en) |-> vld_reg[LAT-1:1] == $past(vld_reg[LAT-2:0]))
        else $error("valid bits did not advance with the pipeline");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$past(en) |-> vld_reg == $past(vld_reg))
        else $error("valid bits moved during a stall");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("input transfer not captured in first stage");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");
`endif

endmodule

`default_nettype wire

/* test/calendar_to_epoch_milliseconds_unit_tb.sv */
// calendar_to_epoch_milliseconds_unit_tb: self-checking testbench for the calendar time to
// epoch millisecond converter, with random idling on both channels
// depends on cte_pkg and calendar_to_epoch_milliseconds_unit
`default_nettype none

module calendar_to_epoch_milliseconds_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ORIGIN_YEAR   = 1970;
    localparam int LEAPS_TO_BASE = (ORIGIN_YEAR - 1) / 4 - (ORIGIN_YEAR - 1) / 100
                                 + (ORIGIN_YEAR - 1) / 400;
    localparam int RANDOM_ITEMS  = 450;
    localparam int TAIL_ITEMS    = 60;
    localparam int DRAIN_AT      = 300;
    localparam int HOLD_AT       = 100;
    localparam int LONG_HOLD     = 80;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 200000;

    localparam int unsigned MONTH_START [13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                                 304, 334, 365};

    typedef struct packed {
        logic [cte_pkg::YEAR_W-1:0]   year;
        logic [cte_pkg::MONTH_W-1:0]  month;
        logic [cte_pkg::DAY_W-1:0]    day;
        logic [cte_pkg::HOUR_W-1:0]   hour;
        logic [cte_pkg::MINUTE_W-1:0] minute;
        logic [cte_pkg::SECOND_W-1:0] second;
        logic [cte_pkg::MILLI_W-1:0]  milli;
    } cal_time_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    logic [cte_pkg::YEAR_W-1:0]    s_year_in   = '0;
    logic [cte_pkg::MONTH_W-1:0]   s_month_in  = '0;
    logic [cte_pkg::DAY_W-1:0]     s_day_in    = '0;
    logic [cte_pkg::HOUR_W-1:0]    s_hour_in   = '0;
    logic [cte_pkg::MINUTE_W-1:0]  s_minute_in = '0;
    logic [cte_pkg::SECOND_W-1:0]  s_second_in = '0;
    logic [cte_pkg::MILLI_W-1:0]   s_milli_in  = '0;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    logic [cte_pkg::EPOCH_W-1:0]   m_epoch_ms;

    cal_time_t                   pending_times [$];
    logic [cte_pkg::EPOCH_W-1:0] expected_ms [$];
    cal_time_t                   offered;
    int                          sent_count = 0;
    int                          recv_count = 0;
    int                          failures   = 0;
    int                          cycles     = 0;

    calendar_to_epoch_milliseconds_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_year_in   (s_year_in),
        .s_month_in  (s_month_in),
        .s_day_in    (s_day_in),
        .s_hour_in   (s_hour_in),
        .s_minute_in (s_minute_in),
        .s_second_in (s_second_in),
        .s_milli_in  (s_milli_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_epoch_ms  (m_epoch_ms)
    );

    always #5 aclk = ~aclk;

    function automatic logic [cte_pkg::EPOCH_W-1:0] epoch_ms_of(input cal_time_t t);
        longint unsigned y;
        longint unsigned days;
        longint unsigned secs;
        int unsigned     midx;
        logic            leap;
        begin
            y    = 64'(t.year);
            days = 0;
            // whole years since the epoch, gregorian leap rule in closed form
            if (y > ORIGIN_YEAR)
                days = (y - ORIGIN_YEAR) * 365 + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400
                     - LEAPS_TO_BASE;
            midx = (t.month == 0) ? 0 : t.month - 1;
            if (midx > 12)
                midx = 12;
            leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
            days = days + MONTH_START[midx] + ((leap && midx >= 2) ? 1 : 0);
            if (t.day > 0)
                days = days + t.day - 1;
            secs = days * 86400 + longint'(t.hour) * 3600 + longint'(t.minute) * 60
                 + longint'(t.second);
            return cte_pkg::EPOCH_W'(secs * 1000 + longint'(t.milli));
        end
    endfunction

    task automatic add_time(input int y, input int mo, input int d, input int h,
                            input int mi, input int s, input int ms);
        cal_time_t t;
        begin
            t.year   = cte_pkg::YEAR_W'(y);
            t.month  = cte_pkg::MONTH_W'(mo);
            t.day    = cte_pkg::DAY_W'(d);
            t.hour   = cte_pkg::HOUR_W'(h);
            t.minute = cte_pkg::MINUTE_W'(mi);
            t.second = cte_pkg::SECOND_W'(s);
            t.milli  = cte_pkg::MILLI_W'(ms);
            pending_times.push_back(t);
        end
    endtask

    // sender: one item in flight on the input channel, prediction at each transfer
    always @(posedge aclk) begin : sender
        int send_gap;
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_ms.push_back(epoch_ms_of(offered));
                sent_count++;
            end
            if (!(s_valid && !s_ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_times.size() == 0 ||
                             (sent_count == DRAIN_AT && expected_ms.size() != 0)) begin
                    s_valid <= 1'b0;
                end else if (pending_times.size() >= TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 16);
                    s_valid <= 1'b0;
                end else begin
                    offered = pending_times.pop_front();
                    s_year_in   <= offered.year;
                    s_month_in  <= offered.month;
                    s_day_in    <= offered.day;
                    s_hour_in   <= offered.hour;
                    s_minute_in <= offered.minute;
                    s_second_in <= offered.second;
                    s_milli_in  <= offered.milli;
                    s_valid     <= 1'b1;
                end
            end
        end
    end

    // receiver: checks each transfer against the oldest prediction
    always @(posedge aclk) begin : receiver
        logic [cte_pkg::EPOCH_W-1:0] want;
        int stall;
        int hold_left;
        bit held_long;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall = 0;
            hold_left = 0;
            held_long = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                recv_count++;
                if (expected_ms.size() == 0) begin
                    $error("m_epoch_ms: expected none, actual %0d", m_epoch_ms);
                    failures++;
                end else begin
                    want = expected_ms.pop_front();
                    if (m_epoch_ms !== want) begin
                        $error("m_epoch_ms: expected %0d, actual %0d", want, m_epoch_ms);
                        failures++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!held_long && recv_count >= HOLD_AT) begin
                held_long = 1'b1;
                hold_left = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if (pending_times.size() >= TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(0, 16);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL calendar_to_epoch_milliseconds_unit");
            $finish;
        end
    end

    initial begin
        cal_time_t t;
        int        r;
        // epoch, top of the nominal range, all ones and all zeros
        add_time(1970, 1, 1, 0, 0, 0, 0);
        add_time(9999, 12, 31, 23, 59, 59, 999);
        add_time(16383, 15, 31, 31, 63, 63, 1023);
        add_time(0, 0, 0, 0, 0, 0, 0);
        // years before the epoch
        add_time(1969, 12, 31, 23, 59, 59, 999);
        add_time(1900, 3, 1, 12, 0, 0, 1);
        // month zero and months above twelve
        add_time(2000, 0, 15, 6, 30, 0, 500);
        add_time(2023, 13, 1, 0, 0, 0, 0);
        add_time(2024, 15, 1, 0, 0, 0, 0);
        // day zero and days past the month's end
        add_time(2020, 3, 0, 1, 2, 3, 4);
        add_time(2023, 2, 31, 0, 0, 0, 0);
        // leap years, leap centuries and common centuries
        add_time(2024, 2, 29, 23, 59, 59, 999);
        add_time(2024, 3, 1, 0, 0, 0, 0);
        add_time(2000, 3, 1, 0, 0, 0, 0);
        add_time(2100, 3, 1, 0, 0, 0, 0);
        add_time(2400, 12, 31, 0, 0, 0, 0);
        add_time(1971, 1, 1, 0, 0, 0, 0);
        add_time(1972, 12, 31, 0, 0, 0, 0);
        add_time(2038, 1, 19, 3, 14, 7, 999);
        // time of day past its usual end, year past the nominal range
        add_time(2023, 6, 15, 31, 63, 63, 1023);
        add_time(10000, 1, 1, 0, 0, 0, 0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            r = $urandom_range(0, 9);
            if (r < 8) begin
                t.year   = cte_pkg::YEAR_W'((r == 7) ? $urandom_range(1960, 2410)
                                                     : $urandom_range(1970, 9999));
                t.month  = cte_pkg::MONTH_W'($urandom_range(1, 12));
                t.day    = cte_pkg::DAY_W'($urandom_range(1, 31));
                t.hour   = cte_pkg::HOUR_W'($urandom_range(0, 23));
                t.minute = cte_pkg::MINUTE_W'($urandom_range(0, 59));
                t.second = cte_pkg::SECOND_W'($urandom_range(0, 59));
                t.milli  = cte_pkg::MILLI_W'($urandom_range(0, 999));
            end else begin
                t.year   = cte_pkg::YEAR_W'($urandom());
                t.month  = cte_pkg::MONTH_W'($urandom());
                t.day    = cte_pkg::DAY_W'($urandom());
                t.hour   = cte_pkg::HOUR_W'($urandom());
                t.minute = cte_pkg::MINUTE_W'($urandom());
                t.second = cte_pkg::SECOND_W'($urandom());
                t.milli  = cte_pkg::MILLI_W'($urandom());
            end
            pending_times.push_back(t);
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_times.size() != 0 || s_valid)
            @(posedge aclk);
        while (expected_ms.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (failures == 0 && expected_ms.size() == 0)
            $display("PASS calendar_to_epoch_milliseconds_unit");
        else
            $display("FAIL calendar_to_epoch_milliseconds_unit");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
design/cte_pkg.sv
design/cte_days.sv
design/cte_ms.sv
design/calendar_to_epoch_milliseconds_unit.sv
test/calendar_to_epoch_milliseconds_unit_tb.sv
